/* rtl/cnss_pkg.sv */
// ----------------------------------------------------------------------------
// Circular nearest smaller span: shared definitions
// Beat types, constants and the controller state type used by the unit.
// ----------------------------------------------------------------------------
package cnss_pkg;

    localparam int MAX_LEN_DEFAULT = 1024;
    localparam int VALUE_W         = 32;
    localparam int IDX_OUT_W       = 11;
    localparam int SPAN_OUT_W      = 12;
    // The running minimum starts here; a span at or above it never wins.
    localparam int SPAN_LIMIT      = 4095;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      is_last;
    } s_item_t;

    typedef struct packed {
        logic                  found;
        logic [IDX_OUT_W-1:0]  left_index;
        logic [IDX_OUT_W-1:0]  middle_index;
        logic [IDX_OUT_W-1:0]  right_index;
        logic [SPAN_OUT_W-1:0] span;
    } m_item_t;

    typedef struct packed {
        logic clear;   // restart the running minimum
        logic issue;   // a neighbour read is issued this cycle
    } sel_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_PASS,
        ST_SELECT,
        ST_FLUSH
    } state_t;

endpackage

/* rtl/circular_nearest_smaller_span_unit.sv */
// ----------------------------------------------------------------------------
// Circular nearest smaller span unit
// Collects a circular sequence, runs a two-pass monotonic stack over it in
// memory, and reports the position with the least neighbour span.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                    | Beat carries
//  --------+--------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data | one sequence element, last marker
//  result  | m_valid, m_ready, m_data | found flag, three indexes, span
//
// Loading takes one input beat per cycle; each beat that the store has room
// for writes the value store and zeroes that position's neighbour entries.
// A beat with is_last set starts the evaluation: a start state, then two
// passes that place each element in turn and pop the stack one entry at a
// time (pops never exceed pushes), then a scan of every element through the
// selection pipeline and a drain. The input stays stalled during evaluation.
// A finished result sits in the output register while the next sequence
// loads; a new result waits only if that register is still full. Reset is
// synchronous and active low and needs no clearing pass.
//
module circular_nearest_smaller_span_unit #(
    parameter int MAX_LEN = cnss_pkg::MAX_LEN_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cnss_pkg::s_item_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cnss_pkg::m_item_t m_data
);
    import cnss_pkg::*;

    localparam int IDX_W     = $clog2(MAX_LEN + 1);
    localparam int STK_DEPTH = 2 * MAX_LEN;
    localparam int STK_AW    = $clog2(STK_DEPTH);
    localparam int SP_W      = $clog2(STK_DEPTH + 1);
    localparam int STK_W     = VALUE_W + IDX_W;

    // Storage. Entry 0 of the per-position memories is never used, so the
    // 1-based positions address them directly.
    logic signed [VALUE_W-1:0] value_mem [0:MAX_LEN];
    logic [IDX_W-1:0]          prev_mem  [0:MAX_LEN];
    logic [IDX_W-1:0]          next_mem  [0:MAX_LEN];
    // The stack memory holds every entry below the top; the top itself is
    // kept in registers so a compare never waits on a read.
    logic [STK_W-1:0]          stk_mem   [0:STK_DEPTH-1];

    logic signed [VALUE_W-1:0] val_q;
    logic [IDX_W-1:0]          prev_q, next_q;
    logic [STK_W-1:0]          stk_q;

    // Memory port controls.
    logic                      val_we, val_re;
    logic [IDX_W-1:0]          val_waddr, val_raddr;
    logic signed [VALUE_W-1:0] val_wdata;
    logic                      prev_we, next_we;
    logic [IDX_W-1:0]          prev_waddr, next_waddr;
    logic [IDX_W-1:0]          prev_wdata, next_wdata;
    logic                      stk_we, stk_re;
    logic [STK_AW-1:0]         stk_waddr, stk_raddr;
    logic [STK_W-1:0]          stk_wdata;

    // Controller state.
    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          len_reg, len_next;
    logic [IDX_W-1:0]          i_reg, i_next;
    logic                      pass_reg, pass_next;
    logic [SP_W-1:0]           sp_reg, sp_next;
    logic                      top_sel_reg, top_sel_next;
    logic signed [VALUE_W-1:0] top_val_reg, top_val_next;
    logic [IDX_W-1:0]          top_idx_reg, top_idx_next;
    logic [IDX_W-1:0]          sel_i_reg, sel_i_next;
    logic                      m_valid_reg, m_valid_next;
    m_item_t                   m_item_reg, m_item_next;

    // Working signals.
    logic [IDX_W-1:0]          cnt_inc;
    logic [SP_W-1:0]           sp_m1, sp_m2;
    logic signed [VALUE_W-1:0] cur_val;
    logic [IDX_W-1:0]          cur_idx;
    logic                      pop;

    sel_ctrl_t                 sel_ctrl;
    logic                      sel_busy;
    m_item_t                   sel_result;

    // The current top of stack comes from the memory right after a pop,
    // and from the registers otherwise.
    assign cur_val = top_sel_reg ? $signed(stk_q[STK_W-1 -: VALUE_W]) : top_val_reg;
    assign cur_idx = top_sel_reg ? stk_q[IDX_W-1:0] : top_idx_reg;
    assign cnt_inc = count_reg + IDX_W'(1);
    assign sp_m1   = sp_reg - SP_W'(1);
    assign sp_m2   = sp_reg - SP_W'(2);
    // Pop while the top is strictly greater than the element being placed.
    assign pop     = (sp_reg != '0) && (cur_val > val_q);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        i_next       = i_reg;
        pass_next    = pass_reg;
        sp_next      = sp_reg;
        top_sel_next = top_sel_reg;
        top_val_next = top_val_reg;
        top_idx_next = top_idx_reg;
        sel_i_next   = sel_i_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;

        val_we     = 1'b0;
        val_waddr  = cnt_inc;
        val_wdata  = s_data.sample_value;
        val_re     = 1'b0;
        val_raddr  = IDX_W'(1);
        prev_we    = 1'b0;
        prev_waddr = cnt_inc;
        prev_wdata = '0;
        next_we    = 1'b0;
        next_waddr = cnt_inc;
        next_wdata = '0;
        stk_we     = 1'b0;
        stk_waddr  = sp_m1[STK_AW-1:0];
        stk_wdata  = {cur_val, cur_idx};
        stk_re     = 1'b0;
        stk_raddr  = sp_m2[STK_AW-1:0];

        sel_ctrl.clear = 1'b0;
        sel_ctrl.issue = 1'b0;

        s_ready = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // Once the store is full, further values are dropped.
                    if (count_reg < IDX_W'(MAX_LEN)) begin
                        count_next = cnt_inc;
                        val_we     = 1'b1;
                        prev_we    = 1'b1;
                        next_we    = 1'b1;
                    end
                    if (s_data.is_last) begin
                        len_next   = (count_reg < IDX_W'(MAX_LEN)) ? cnt_inc : count_reg;
                        count_next = '0;
                        state_next = ST_START;
                    end
                end
            end

            ST_START: begin
                val_re         = 1'b1;
                val_raddr      = IDX_W'(1);
                i_next         = IDX_W'(1);
                pass_next      = 1'b0;
                sp_next        = '0;
                top_sel_next   = 1'b0;
                sel_ctrl.clear = 1'b1;
                state_next     = ST_PASS;
            end

            ST_PASS: begin
                if (pop) begin
                    next_we    = 1'b1;
                    next_waddr = cur_idx;
                    next_wdata = i_reg;
                    sp_next    = sp_m1;
                    // Fetch the new top; it is valid in the next cycle.
                    stk_re       = (sp_reg > SP_W'(1));
                    top_sel_next = (sp_reg > SP_W'(1));
                end else begin
                    if (sp_reg != '0) begin
                        prev_we    = 1'b1;
                        prev_waddr = i_reg;
                        prev_wdata = cur_idx;
                        stk_we     = 1'b1;
                    end
                    top_val_next = val_q;
                    top_idx_next = i_reg;
                    top_sel_next = 1'b0;
                    sp_next      = sp_reg + SP_W'(1);
                    if (i_reg == len_reg) begin
                        if (pass_reg) begin
                            sel_i_next = IDX_W'(1);
                            state_next = ST_SELECT;
                        end else begin
                            pass_next = 1'b1;
                            i_next    = IDX_W'(1);
                            val_re    = 1'b1;
                            val_raddr = IDX_W'(1);
                        end
                    end else begin
                        i_next    = i_reg + IDX_W'(1);
                        val_re    = 1'b1;
                        val_raddr = i_reg + IDX_W'(1);
                    end
                end
            end

            ST_SELECT: begin
                sel_ctrl.issue = 1'b1;
                if (sel_i_reg == len_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    sel_i_next = sel_i_reg + IDX_W'(1);
                end
            end

            ST_FLUSH: begin
                // Wait for the pipeline to drain and the output register to
                // be free before posting the result.
                if (!sel_busy && (!m_valid_reg || m_ready)) begin
                    m_item_next  = sel_result;
                    m_valid_next = 1'b1;
                    state_next   = ST_LOAD;
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            len_reg     <= '0;
            i_reg       <= '0;
            pass_reg    <= 1'b0;
            sp_reg      <= '0;
            top_sel_reg <= 1'b0;
            sel_i_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            i_reg       <= i_next;
            pass_reg    <= pass_next;
            sp_reg      <= sp_next;
            top_sel_reg <= top_sel_next;
            sel_i_reg   <= sel_i_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_val_reg <= top_val_next;
        top_idx_reg <= top_idx_next;
        m_item_reg  <= m_item_next;
    end

    // Value store.
    always_ff @(posedge aclk) begin
        if (val_we) begin
            value_mem[val_waddr] <= val_wdata;
        end
        if (val_re) begin
            val_q <= value_mem[val_raddr];
        end
    end

    // Neighbour tables share the read address driven by the selection scan.
    always_ff @(posedge aclk) begin
        if (prev_we) begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (next_we) begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (sel_ctrl.issue) begin
            prev_q <= prev_mem[sel_i_reg];
            next_q <= next_mem[sel_i_reg];
        end
    end

    // Index stack.
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_q <= stk_mem[stk_raddr];
        end
    end

    cnss_span_select #(
        .MAX_LEN(MAX_LEN)
    ) u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (sel_ctrl),
        .issue_idx (sel_i_reg),
        .len       (len_reg),
        .prev_q    (prev_q),
        .next_q    (next_q),
        .busy      (sel_busy),
        .result    (sel_result)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_item_reg;

    // A top taken from the stack memory only exists while the stack holds
    // at least one entry.
    a_top_sel_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        top_sel_reg |-> (sp_reg != '0))
        else $error("stack top selected from memory with an empty stack");

    // The pass index always names a loaded position.
    a_pass_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PASS) |-> ((i_reg != '0) && (i_reg <= len_reg)))
        else $error("stack pass index out of range");

    // The selection scan stays within the loaded sequence.
    a_select_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SELECT) |-> ((sel_i_reg != '0) && (sel_i_reg <= len_reg)))
        else $error("selection index out of range");

    // Each pass pushes every element once, so the stack never exceeds twice
    // the sequence length.
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PASS) |-> ((SP_W + 1)'(sp_reg) <= {len_reg, 1'b0}))
        else $error("stack pointer beyond twice the sequence length");

endmodule

/* rtl/cnss_span_select.sv */
// ----------------------------------------------------------------------------
// Circular nearest smaller span: span selection pipeline
// Takes one neighbour pair per cycle from memory and keeps the least span.
// ----------------------------------------------------------------------------
module cnss_span_select #(
    parameter  int MAX_LEN = cnss_pkg::MAX_LEN_DEFAULT,
    localparam int IDX_W   = $clog2(MAX_LEN + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cnss_pkg::sel_ctrl_t ctrl,
    input  logic [IDX_W-1:0]    issue_idx,
    input  logic [IDX_W-1:0]    len,
    input  logic [IDX_W-1:0]    prev_q,
    input  logic [IDX_W-1:0]    next_q,
    output logic                busy,
    output cnss_pkg::m_item_t   result
);
    import cnss_pkg::*;

    localparam int SUM_W  = $clog2(2 * MAX_LEN + 1);
    localparam int SPAN_W = (SUM_W > SPAN_OUT_W) ? SUM_W : SPAN_OUT_W;

    logic             rd_vld_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             d_vld_reg;
    logic [IDX_W-1:0] d1_reg, d2_reg, l_reg, m_reg, r_reg;
    logic             found_reg;
    logic [SPAN_W-1:0] best_reg;
    logic [IDX_W-1:0] bl_reg, bm_reg, br_reg;

    logic [IDX_W-1:0]  d1_next, d2_next;
    logic              qual;
    logic [SPAN_W-1:0] span_sum;
    logic              take;

    always_comb begin
        d1_next = (rd_idx_reg > prev_q) ? rd_idx_reg - prev_q : len - (prev_q - rd_idx_reg);
        d2_next = (next_q > rd_idx_reg) ? next_q - rd_idx_reg : len - (rd_idx_reg - next_q);
        qual    = (prev_q != '0) && (next_q != '0);
        span_sum = SPAN_W'(d1_reg) + SPAN_W'(d2_reg);
        // Strict compare keeps the lowest position on a tie.
        take    = d_vld_reg && (span_sum < best_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            d_vld_reg  <= 1'b0;
            found_reg  <= 1'b0;
            best_reg   <= SPAN_W'(SPAN_LIMIT);
            bl_reg     <= '0;
            bm_reg     <= '0;
            br_reg     <= '0;
        end else begin
            rd_vld_reg <= ctrl.issue;
            d_vld_reg  <= rd_vld_reg && qual;
            if (ctrl.clear) begin
                found_reg <= 1'b0;
                best_reg  <= SPAN_W'(SPAN_LIMIT);
                bl_reg    <= '0;
                bm_reg    <= '0;
                br_reg    <= '0;
            end else if (take) begin
                found_reg <= 1'b1;
                best_reg  <= span_sum;
                bl_reg    <= l_reg;
                bm_reg    <= m_reg;
                br_reg    <= r_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= issue_idx;
        d1_reg     <= d1_next;
        d2_reg     <= d2_next;
        l_reg      <= prev_q;
        m_reg      <= rd_idx_reg;
        r_reg      <= next_q;
    end

    assign busy = rd_vld_reg | d_vld_reg;

    always_comb begin
        result.found        = found_reg;
        result.left_index   = IDX_OUT_W'(bl_reg);
        result.middle_index = IDX_OUT_W'(bm_reg);
        result.right_index  = IDX_OUT_W'(br_reg);
        result.span         = found_reg ? SPAN_OUT_W'(best_reg) : '0;
    end

endmodule
